// ----- rtl/ttli_pkg.sv -----
package ttli_pkg;

  localparam int DATA_W   = 48;
  localparam int DEF_ROWS = 256;
  localparam int DEF_COLS = 16;
  localparam int CNT_W    = 9;
  localparam int NCOL_W   = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] OP_TIME   = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [2:0] ST_INTERP = 3'd0;
  localparam logic [2:0] ST_FIRST  = 3'd1;
  localparam logic [2:0] ST_LAST   = 3'd2;
  localparam logic [2:0] ST_ZERO   = 3'd3;
  localparam logic [2:0] ST_EMPTY  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  typedef struct packed {
    logic times_we;
    logic times_re;
    logic smp_we;
    logic smp_re;
  } mem_ctl_t;

endpackage

// ----- rtl/ttli_if.sv -----
interface ttli_in_if;
  import ttli_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               opcode;
  logic [7:0]               row;
  logic [3:0]               column;
  logic signed [DATA_W-1:0] write_value;
  logic signed [DATA_W-1:0] query_time;
  modport source (output valid, opcode, row, column, write_value, query_time, input ready);
  modport sink (input valid, opcode, row, column, write_value, query_time, output ready);
endinterface

interface ttli_out_if;
  import ttli_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [3:0]               out_column;
  logic signed [DATA_W-1:0] out_value;
  logic [2:0]               status;
  logic                     last;
  modport source (output valid, out_column, out_value, status, last, input ready);
  modport sink (input valid, out_column, out_value, status, last, output ready);
endinterface

interface ttli_cfg_if;
  import ttli_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CNT_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/ttli_store.sv -----
module ttli_store
  import ttli_pkg::*;
#(
  parameter int ROWS = DEF_ROWS,
  parameter int COLS = DEF_COLS,
  parameter int RAW  = $clog2(ROWS),
  parameter int CAW  = (COLS > 1) ? $clog2(COLS) : 1
) (
  input  logic              clk,
  input  mem_ctl_t          ctl,
  input  logic [RAW-1:0]    times_addr,
  input  logic [RAW+CAW-1:0] smp_addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] times_rdata,
  output logic [DATA_W-1:0] smp_rdata
);

  logic [DATA_W-1:0] times_mem [ROWS];
  logic [DATA_W-1:0] smp_mem [ROWS << CAW];

  always_ff @(posedge clk) begin
    if (ctl.times_we) begin
      times_mem[times_addr] <= wdata;
    end
    if (ctl.times_re) begin
      times_rdata <= times_mem[times_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.smp_we) begin
      smp_mem[smp_addr] <= wdata;
    end
    if (ctl.smp_re) begin
      smp_rdata <= smp_mem[smp_addr];
    end
  end

endmodule

// ----- rtl/ttli_div.sv -----
module ttli_div
  import ttli_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] num,
  input  logic [DATA_W-1:0] den,
  output logic              done,
  output logic [16:0]       q
);

  logic [DATA_W:0]   rem_r, rem_nxt;
  logic [DATA_W-1:0] den_r, den_nxt;
  logic [16:0]       q_r, q_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              ge;
  logic [DATA_W:0]   rsub;
  logic [16:0]       qs;
  logic [17:0]       qr;

  always_comb begin
    ge       = rem_r >= {1'b0, den_r};
    rsub     = ge ? rem_r - {1'b0, den_r} : rem_r;
    qs       = {q_r[15:0], ge};
    qr       = {1'b0, qs} + 18'(({rsub[DATA_W-1:0], 1'b0} >= {1'b0, den_r}) ? 1 : 0);
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = {1'b0, num};
      den_nxt  = den;
      q_nxt    = '0;
      cnt_nxt  = 5'd17;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        q_nxt    = (qr > 18'd65536) ? 17'd65536 : qr[16:0];
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        q_nxt   = qs;
        rem_nxt = {rsub[DATA_W-1:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// ----- rtl/ttli_ctrl.sv -----
module ttli_ctrl
  import ttli_pkg::*;
#(
  parameter int ROWS = DEF_ROWS,
  parameter int COLS = DEF_COLS,
  parameter int RAW  = $clog2(ROWS),
  parameter int CAW  = (COLS > 1) ? $clog2(COLS) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  ttli_in_if.sink            in_ch,
  ttli_out_if.source         out_ch,
  ttli_cfg_if.sink           cfg_ch,
  output mem_ctl_t           mem_ctl,
  output logic [RAW-1:0]     times_addr,
  output logic [RAW+CAW-1:0] smp_addr,
  output logic [DATA_W-1:0]  mem_wdata,
  input  logic [DATA_W-1:0]  times_rdata,
  input  logic [DATA_W-1:0]  smp_rdata,
  output logic               div_start,
  output logic [DATA_W-1:0]  div_num,
  output logic [DATA_W-1:0]  div_den,
  input  logic               div_done,
  input  logic [16:0]        div_q
);

  localparam int NRW   = $clog2(ROWS + 1);
  localparam int NCMAX = (COLS < 16) ? COLS : 16;

  typedef enum logic [3:0] {
    S_IDLE, S_EMPTY, S_FIRST, S_LASTT, S_SCAN, S_DIV,
    S_P0, S_P1, S_MUL, S_FIN, S_HOLD_RD, S_HOLD
  } state_t;

  state_t                   state_r, state_nxt;
  logic signed [DATA_W-1:0] t_r, t_nxt;
  logic [NRW-1:0]           nrow_r, nrow_nxt;
  logic [NCOL_W-1:0]        ncol_r, ncol_nxt;
  logic [RAW-1:0]           i_r, i_nxt;
  logic signed [DATA_W-1:0] prev_r, prev_nxt;
  logic [RAW-1:0]           hrow_r, hrow_nxt;
  logic [2:0]               hstat_r, hstat_nxt;
  logic [3:0]               col_r, col_nxt;
  logic [16:0]              q_r, q_nxt;
  logic signed [DATA_W-1:0] p0_r, p0_nxt;
  logic [DATA_W-1:0]        mag_r, mag_nxt;
  logic                     neg_r, neg_nxt;
  logic [64:0]              prod_r, prod_nxt;
  logic [CNT_W-1:0]         rows_cfg_r;
  logic [NCOL_W-1:0]        cols_cfg_r;

  logic                     ovalid_r, ovalid_nxt;
  logic [3:0]               ocol_r, ocol_nxt;
  logic [DATA_W-1:0]        oval_r, oval_nxt;
  logic [2:0]               ostat_r, ostat_nxt;
  logic                     olast_r, olast_nxt;

  logic                     in_acc, out_free, is_last, row_ok, col_ok;
  logic [NRW-1:0]           nrow_calc;
  logic [NCOL_W-1:0]        ncol_calc;
  logic signed [DATA_W-1:0] tr_s, sr_s;
  logic signed [DATA_W:0]   diff, tdiff;
  logic [DATA_W:0]          step;
  logic signed [DATA_W+1:0] v;
  logic [DATA_W-1:0]        vsat;
  logic [RAW-1:0]           last_row;

  function automatic logic [RAW+CAW-1:0] saddr(input logic [RAW-1:0] r, input logic [3:0] c);
    logic [CAW-1:0] cx;
    cx = CAW'(c);
    return {r, cx};
  endfunction

  always_comb begin
    tr_s      = times_rdata;
    sr_s      = smp_rdata;
    in_acc    = in_ch.valid && in_ch.ready;
    out_free  = !ovalid_r || out_ch.ready;
    is_last   = ({1'b0, col_r} + 5'd1) == ncol_r;
    row_ok    = 32'(in_ch.row) < ROWS;
    col_ok    = 32'(in_ch.column) < COLS;
    nrow_calc = (32'(rows_cfg_r) > ROWS) ? NRW'(ROWS) : NRW'(rows_cfg_r);
    if (cols_cfg_r == '0) begin
      ncol_calc = NCOL_W'(1);
    end else if (32'(cols_cfg_r) > NCMAX) begin
      ncol_calc = NCOL_W'(NCMAX);
    end else begin
      ncol_calc = cols_cfg_r;
    end
    last_row  = RAW'(nrow_r - NRW'(1));
    diff      = {sr_s[DATA_W-1], sr_s} - {p0_r[DATA_W-1], p0_r};
    tdiff     = {t_r[DATA_W-1], t_r} - {prev_r[DATA_W-1], prev_r};
    step      = (DATA_W + 1)'((prod_r + 65'd32768) >> 16);
    v         = neg_r ? {{2{p0_r[DATA_W-1]}}, p0_r} - {1'b0, step}
                      : {{2{p0_r[DATA_W-1]}}, p0_r} + {1'b0, step};
    if (v[DATA_W+1:DATA_W-1] == 3'b000 || v[DATA_W+1:DATA_W-1] == 3'b111) begin
      vsat = v[DATA_W-1:0];
    end else if (!v[DATA_W+1]) begin
      vsat = {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      vsat = {1'b1, {(DATA_W-1){1'b0}}};
    end

    state_nxt  = state_r;
    t_nxt      = t_r;
    nrow_nxt   = nrow_r;
    ncol_nxt   = ncol_r;
    i_nxt      = i_r;
    prev_nxt   = prev_r;
    hrow_nxt   = hrow_r;
    hstat_nxt  = hstat_r;
    col_nxt    = col_r;
    q_nxt      = q_r;
    p0_nxt     = p0_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    prod_nxt   = prod_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    ocol_nxt   = ocol_r;
    oval_nxt   = oval_r;
    ostat_nxt  = ostat_r;
    olast_nxt  = olast_r;
    mem_ctl    = '0;
    times_addr = '0;
    smp_addr   = '0;
    mem_wdata  = in_ch.write_value;
    div_start  = 1'b0;
    div_num    = tdiff[DATA_W-1:0];
    div_den    = DATA_W'(tr_s - prev_r);

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_ch.opcode)
            OP_TIME: begin
              mem_ctl.times_we = row_ok;
              times_addr       = RAW'(in_ch.row);
            end
            OP_SAMPLE: begin
              mem_ctl.smp_we = row_ok && col_ok;
              smp_addr       = saddr(RAW'(in_ch.row), in_ch.column);
            end
            OP_QUERY: begin
              t_nxt    = in_ch.query_time;
              nrow_nxt = nrow_calc;
              ncol_nxt = ncol_calc;
              col_nxt  = '0;
              if (nrow_calc == '0) begin
                state_nxt = S_EMPTY;
              end else begin
                mem_ctl.times_re = 1'b1;
                state_nxt        = S_FIRST;
              end
            end
            default: ;
          endcase
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ocol_nxt   = '0;
          oval_nxt   = '0;
          ostat_nxt  = ST_EMPTY;
          olast_nxt  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_FIRST: begin
        prev_nxt = tr_s;
        if (nrow_r == NRW'(1) || t_r <= tr_s) begin
          hrow_nxt  = '0;
          hstat_nxt = ST_FIRST;
          state_nxt = S_HOLD_RD;
        end else begin
          mem_ctl.times_re = 1'b1;
          times_addr       = last_row;
          state_nxt        = S_LASTT;
        end
      end
      S_LASTT: begin
        if (t_r >= tr_s) begin
          hrow_nxt  = last_row;
          hstat_nxt = ST_LAST;
          state_nxt = S_HOLD_RD;
        end else begin
          i_nxt            = '0;
          mem_ctl.times_re = 1'b1;
          times_addr       = RAW'(1);
          state_nxt        = S_SCAN;
        end
      end
      S_SCAN: begin
        if (t_r >= prev_r && t_r <= tr_s) begin
          if (tr_s <= prev_r) begin
            hrow_nxt  = i_r;
            hstat_nxt = ST_ZERO;
            state_nxt = S_HOLD_RD;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end else if ((NRW + 1)'(i_r) + (NRW + 1)'(2) < (NRW + 1)'(nrow_r)) begin
          i_nxt            = i_r + RAW'(1);
          prev_nxt         = tr_s;
          mem_ctl.times_re = 1'b1;
          times_addr       = i_r + RAW'(2);
        end else begin
          hrow_nxt  = last_row;
          hstat_nxt = ST_LAST;
          state_nxt = S_HOLD_RD;
        end
      end
      S_DIV: begin
        if (div_done) begin
          q_nxt          = div_q;
          mem_ctl.smp_re = 1'b1;
          smp_addr       = saddr(i_r, col_r);
          state_nxt      = S_P0;
        end
      end
      S_P0: begin
        p0_nxt         = sr_s;
        mem_ctl.smp_re = 1'b1;
        smp_addr       = saddr(i_r + RAW'(1), col_r);
        state_nxt      = S_P1;
      end
      S_P1: begin
        neg_nxt   = diff[DATA_W];
        mag_nxt   = diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = 65'(mag_r) * 65'(q_r);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ocol_nxt   = col_r;
          oval_nxt   = vsat;
          ostat_nxt  = ST_INTERP;
          olast_nxt  = is_last;
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            col_nxt        = col_r + 4'd1;
            mem_ctl.smp_re = 1'b1;
            smp_addr       = saddr(i_r, col_r + 4'd1);
            state_nxt      = S_P0;
          end
        end
      end
      S_HOLD_RD: begin
        mem_ctl.smp_re = 1'b1;
        smp_addr       = saddr(hrow_r, col_r);
        state_nxt      = S_HOLD;
      end
      S_HOLD: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ocol_nxt   = col_r;
          oval_nxt   = smp_rdata;
          ostat_nxt  = hstat_r;
          olast_nxt  = is_last;
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            col_nxt   = col_r + 4'd1;
            state_nxt = S_HOLD_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ovalid_r   <= 1'b0;
      rows_cfg_r <= '0;
      cols_cfg_r <= NCOL_W'(1);
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_ch.valid && cfg_ch.index == REG_ROWS) begin
        rows_cfg_r <= cfg_ch.data;
      end
      if (cfg_ch.valid && cfg_ch.index == REG_COLS) begin
        cols_cfg_r <= cfg_ch.data[NCOL_W-1:0];
      end
    end
    t_r     <= t_nxt;
    nrow_r  <= nrow_nxt;
    ncol_r  <= ncol_nxt;
    i_r     <= i_nxt;
    prev_r  <= prev_nxt;
    hrow_r  <= hrow_nxt;
    hstat_r <= hstat_nxt;
    col_r   <= col_nxt;
    q_r     <= q_nxt;
    p0_r    <= p0_nxt;
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    prod_r  <= prod_nxt;
    ocol_r  <= ocol_nxt;
    oval_r  <= oval_nxt;
    ostat_r <= ostat_nxt;
    olast_r <= olast_nxt;
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = ovalid_r;
  assign out_ch.out_column = ocol_r;
  assign out_ch.out_value  = oval_r;
  assign out_ch.status     = ostat_r;
  assign out_ch.last       = olast_r;

endmodule

// ----- rtl/time_table_linear_interpolator_unit.sv -----
// piecewise linear interpolation over a table of time breakpoints
// in_ch carries requests: write a row time, write one sample, or query a time.
// out_ch gives one result per column in use for a query (last marks the
// final one); an empty table gives one result with status empty.
// cfg_ch sets rows_in_use (index 0) and columns_in_use (index 1); always ready.
// a write request goes straight into its memory. a query checks the table ends,
// searches the row pairs one after another, runs the serial divider and then,
// per column, does two reads of the one sample memory port, the multiply, then
// output; held rows do one read and then output per column.
// one request is worked at a time; in_ch.ready is high only when idle.
// results go through a one-deep output register; a stalled receiver holds
// the block in place with no loss.
// reset clears control state and the registers to 0 rows and 1 column;
// table memories are not cleared and must be written before use.
module time_table_linear_interpolator_unit
  import ttli_pkg::*;
#(
  parameter int ROWS = DEF_ROWS,
  parameter int COLS = DEF_COLS
) (
  input  logic       clk,
  input  logic       rst_n,
  ttli_in_if.sink    in_ch,
  ttli_out_if.source out_ch,
  ttli_cfg_if.sink   cfg_ch
);

  localparam int RAW = $clog2(ROWS);
  localparam int CAW = (COLS > 1) ? $clog2(COLS) : 1;

  mem_ctl_t           mem_ctl;
  logic [RAW-1:0]     times_addr;
  logic [RAW+CAW-1:0] smp_addr;
  logic [DATA_W-1:0]  mem_wdata, times_rdata, smp_rdata;
  logic               div_start, div_done;
  logic [DATA_W-1:0]  div_num, div_den;
  logic [16:0]        div_q;

  ttli_ctrl #(.ROWS(ROWS), .COLS(COLS), .RAW(RAW), .CAW(CAW)) u_ctrl (
    .clk, .rst_n, .in_ch, .out_ch, .cfg_ch, .mem_ctl, .times_addr, .smp_addr,
    .mem_wdata, .times_rdata, .smp_rdata, .div_start, .div_num, .div_den,
    .div_done, .div_q
  );

  ttli_store #(.ROWS(ROWS), .COLS(COLS), .RAW(RAW), .CAW(CAW)) u_store (
    .clk, .ctl(mem_ctl), .times_addr, .smp_addr, .wdata(mem_wdata),
    .times_rdata, .smp_rdata
  );

  ttli_div u_div (
    .clk, .rst_n, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .q(div_q)
  );

  a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_EMPTY |-> out_ch.last && out_ch.out_value == '0)
    else $error("empty result not single");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.opcode == OP_QUERY |=> !in_ch.ready)
    else $error("query did not block input");

  a_div_once: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> !div_start)
    else $error("divider restarted");

endmodule
